@@ design/dhc_pkg.sv @@
// Shared constants, types and palette tables for the diverging heat-map colormap.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dhc_pkg;

    // Field widths
    localparam int CHANNEL_BITS  = 8;
    localparam int DENSITY_BITS  = 32;

    // Palette: stops are hundredths, 0..99
    localparam int STOP_BITS     = 7;
    localparam int STOP_COUNT    = 11;
    localparam int STOP_IDX_BITS = 4;
    localparam int NUM_CH        = 3;

    // Band split: five bands per half, band quotient always below 8
    localparam int BAND_COUNT    = 5;
    localparam int CAT_Q_BITS    = 3;
    localparam int WIDE_BITS     = DENSITY_BITS + CAT_Q_BITS;

    // Channel scaling: level = round(FULL * num / (100 * span))
    localparam int PCT_SCALE     = 100;
    localparam int HALF_PCT      = 50;
    localparam int PROD_BITS     = DENSITY_BITS + STOP_BITS;
    localparam int DEN_BITS      = DENSITY_BITS + STOP_BITS;
    localparam int NUM_BITS      = DENSITY_BITS + CHANNEL_BITS + STOP_BITS;

    // Stop indexes with a fixed meaning
    localparam logic [STOP_IDX_BITS-1:0] STOP_HOT   = 4'd0;
    localparam logic [STOP_IDX_BITS-1:0] LOWER_BASE = 4'd5;
    localparam logic [STOP_IDX_BITS-1:0] STOP_COLD  = 4'd10;

    // Channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CEILING = 2'd2;
    localparam logic [DENSITY_BITS-1:0] FLOOR_RST   = DENSITY_BITS'(0);
    localparam logic [DENSITY_BITS-1:0] CENTER_RST  = DENSITY_BITS'(65536);
    localparam logic [DENSITY_BITS-1:0] CEILING_RST = DENSITY_BITS'(131072);

    localparam logic [STOP_BITS-1:0] STOP_RED [STOP_COUNT] = '{
        7'd33, 7'd55, 7'd75, 7'd87, 7'd96, 7'd99, 7'd78, 7'd50, 7'd21, 7'd0, 7'd0
    };
    localparam logic [STOP_BITS-1:0] STOP_GREEN [STOP_COUNT] = '{
        7'd19, 7'd32, 7'd51, 7'd76, 7'd91, 7'd96, 7'd92, 7'd80, 7'd59, 7'd40, 7'd24
    };
    localparam logic [STOP_BITS-1:0] STOP_BLUE [STOP_COUNT] = '{
        7'd2, 7'd4, 7'd18, 7'd49, 7'd76, 7'd89, 7'd90, 7'd76, 7'd56, 7'd37, 7'd19
    };

    // Band-select output: stop index of the band start, offset inside the band, band span
    typedef struct packed {
        logic [STOP_IDX_BITS-1:0] cat;
        logic [DENSITY_BITS-1:0]  offset;
        logic [DENSITY_BITS-1:0]  span;
    } t_band_item;

    // Band-select internal stage: base stop plus a band-quotient division in flight
    typedef struct packed {
        logic [STOP_IDX_BITS-1:0] base;
        logic [DENSITY_BITS-1:0]  part;
        logic [CAT_Q_BITS-1:0]    rest;
        logic [CAT_Q_BITS-1:0]    quot;
        logic [DENSITY_BITS-1:0]  span;
    } t_cat_stage;

    // Blend output: rounded-division dividend per channel and common divisor
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_BITS-1:0] numer;
        logic [DEN_BITS-1:0]             den;
    } t_blend_item;

    function automatic logic [STOP_BITS-1:0] stop_level(
        input logic [1:0]               ch,
        input logic [STOP_IDX_BITS-1:0] idx
    );
        logic [STOP_BITS-1:0] lvl;
        lvl = '0;
        if (idx <= STOP_COLD) begin
            case (ch)
                CH_RED:   lvl = STOP_RED[idx];
                CH_GREEN: lvl = STOP_GREEN[idx];
                CH_BLUE:  lvl = STOP_BLUE[idx];
                default:  lvl = '0;
            endcase
        end
        return lvl;
    endfunction

endpackage

@@ design/diverging_heatmap_colormap_unit.sv @@
// Top level of the diverging heat-map colormap: configuration registers and the
// band-select, blend and round-divider pipeline. Depends on dhc_pkg and its modules.
`timescale 1ns / 1ps

// Maps one unsigned Q16.16 density sample to an 8-bit RGB color on an 11-stop
// diverging palette laid over the configured floor, center and ceiling.
//
// Input channel : i_in_valid / o_in_ready, payload i_density_sample.
// Output channel: o_out_valid / i_out_ready, payload o_red_level, o_green_level,
//                 o_blue_level. A transaction moves on valid and ready both high.
// Config port   : i_cfg_wr_en writes i_cfg_data into the register at i_cfg_index
//                 (0 floor, 1 center, 2 ceiling, 3 ignored). Write only when idle.
//
// Throughput: one transaction per cycle while i_out_ready stays high. Pipeline: 15
// register stages (4 band-select + 3 blend + 8 divider). The divider that scales each
// channel resolves one quotient bit per stage.
// Reset: pipeline valid bits clear, bounds return to 0, 1.0 and 2.0.
// Receiver stall: every stage holds its transaction; bubbles are squeezed out,
// and o_in_ready drops once all 15 stages are full. Nothing is lost or repeated.

module diverging_heatmap_colormap_unit import dhc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DENSITY_BITS-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [DENSITY_BITS-1:0] i_density_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CHANNEL_BITS-1:0] o_red_level,
    output logic [CHANNEL_BITS-1:0] o_green_level,
    output logic [CHANNEL_BITS-1:0] o_blue_level
);

    logic [DENSITY_BITS-1:0]             r_floor;
    logic [DENSITY_BITS-1:0]             r_center;
    logic [DENSITY_BITS-1:0]             r_ceiling;

    logic                                band_valid;
    logic                                band_ready;
    t_band_item                          band_item;
    logic                                blend_valid;
    logic                                blend_ready;
    t_blend_item                         blend_item;
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] level;

    // Bound registers. The user must keep them static while transactions are in flight
    // (the block does not enforce it); the band selector reads them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FLOOR_RST;
            r_center  <= CENTER_RST;
            r_ceiling <= CEILING_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FLOOR:   r_floor   <= i_cfg_data;
                CFG_CENTER:  r_center  <= i_cfg_data;
                CFG_CEILING: r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample -> band start stop, offset within band, band span
    dhc_band_select u_band_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_sample  (i_density_sample),
        .i_floor   (r_floor),
        .i_center  (r_center),
        .i_ceiling (r_ceiling),
        .o_valid   (band_valid),
        .i_ready   (band_ready),
        .o_item    (band_item)
    );

    // Palette lookup and interpolation numerator per channel
    dhc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (band_valid),
        .o_ready (band_ready),
        .i_item  (band_item),
        .o_valid (blend_valid),
        .i_ready (blend_ready),
        .o_item  (blend_item)
    );

    // Rounded scale to channel levels; last stage doubles as output register
    dhc_round_div u_round_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (blend_valid),
        .o_ready (blend_ready),
        .i_item  (blend_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_level (level)
    );

    assign o_red_level   = level[CH_RED];
    assign o_green_level = level[CH_GREEN];
    assign o_blue_level  = level[CH_BLUE];

endmodule

@@ design/dhc_band_select.sv @@
// Band select: classifies a sample against the bounds, then finds band index and offset
// with a three-stage restoring division. Depends on dhc_pkg.
`timescale 1ns / 1ps

module dhc_band_select import dhc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [DENSITY_BITS-1:0] i_sample,
    input  logic [DENSITY_BITS-1:0] i_floor,
    input  logic [DENSITY_BITS-1:0] i_center,
    input  logic [DENSITY_BITS-1:0] i_ceiling,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_band_item              o_item
);

    localparam int LAST = CAT_Q_BITS;

    logic [LAST:0]            r_vld;
    logic [LAST+1:0]          stage_ready;
    t_cat_stage               r_st [LAST+1];
    t_cat_stage               n_first;
    logic [STOP_IDX_BITS-1:0] sel_base;
    logic [DENSITY_BITS-1:0]  sel_diff;
    logic [DENSITY_BITS-1:0]  sel_span;
    logic [WIDE_BITS-1:0]     wide;

    // one quotient bit per call, MSB first
    function automatic t_cat_stage cat_step(input t_cat_stage s);
        t_cat_stage            o;
        logic [DENSITY_BITS:0] trial;
        logic                  ge;
        o     = s;
        trial = {s.part, s.rest[CAT_Q_BITS-1]};
        ge    = trial >= {1'b0, s.span};
        o.part = ge ? DENSITY_BITS'(trial - {1'b0, s.span}) : trial[DENSITY_BITS-1:0];
        o.rest = {s.rest[CAT_Q_BITS-2:0], 1'b0};
        o.quot = {s.quot[CAT_Q_BITS-2:0], ge};
        return o;
    endfunction

    // Bounds tested in order ceiling, center, floor; outside both bands the
    // divisor is forced to one so the quotient and offset come out zero.
    always_comb begin
        if (i_sample > i_ceiling) begin
            sel_base = STOP_HOT;
            sel_diff = '0;
            sel_span = DENSITY_BITS'(1);
        end else if (i_sample > i_center) begin
            sel_base = STOP_HOT;
            sel_diff = i_ceiling - i_sample;
            sel_span = i_ceiling - i_center;
        end else if (i_sample > i_floor) begin
            sel_base = LOWER_BASE;
            sel_diff = i_center - i_sample;
            sel_span = i_center - i_floor;
        end else begin
            sel_base = STOP_COLD;
            sel_diff = '0;
            sel_span = DENSITY_BITS'(1);
        end
        wide = WIDE_BITS'(sel_diff) * WIDE_BITS'(BAND_COUNT);
        n_first.base = sel_base;
        n_first.part = wide[WIDE_BITS-1:CAT_Q_BITS];
        n_first.rest = wide[CAT_Q_BITS-1:0];
        n_first.quot = '0;
        n_first.span = sel_span;
    end

    assign stage_ready[LAST+1] = i_ready;
    for (genvar k = 0; k <= LAST; k++) begin : g_ready
        assign stage_ready[k] = !r_vld[k] || stage_ready[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_ready[0]) r_vld[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                if (stage_ready[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready[0]) r_st[0] <= n_first;
        for (int k = 1; k <= LAST; k++) begin
            if (stage_ready[k]) r_st[k] <= cat_step(r_st[k-1]);
        end
    end

    assign o_ready       = stage_ready[0];
    assign o_valid       = r_vld[LAST];
    assign o_item.cat    = r_st[LAST].base + STOP_IDX_BITS'(r_st[LAST].quot);
    assign o_item.offset = r_st[LAST].part;
    assign o_item.span   = r_st[LAST].span;

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_st[0].span != '0)
        else $error("band span is zero");

    for (genvar k = 0; k <= LAST; k++) begin : g_chk
        a_part_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[k] |-> r_st[k].part < r_st[k].span)
            else $error("band remainder not below span");
    end

    a_band_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> r_st[LAST].quot < CAT_Q_BITS'(BAND_COUNT))
        else $error("band quotient out of range");

endmodule

@@ design/dhc_blend.sv @@
// Blend: palette lookup, interpolation products and the rounded-division dividend,
// over three register stages. Depends on dhc_pkg.
`timescale 1ns / 1ps

module dhc_blend import dhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_band_item  i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_blend_item o_item
);

    logic [2:0]               r_vld;
    logic [3:0]               stage_ready;
    logic [STOP_IDX_BITS-1:0] cat_next;
    logic [PROD_BITS-1:0]     n_prod0 [NUM_CH];
    logic [PROD_BITS-1:0]     n_prod1 [NUM_CH];
    logic [PROD_BITS-1:0]     r_prod0 [NUM_CH];
    logic [PROD_BITS-1:0]     r_prod1 [NUM_CH];
    logic [DENSITY_BITS-1:0]  r_span_a;
    logic [PROD_BITS-1:0]     n_num [NUM_CH];
    logic [PROD_BITS-1:0]     r_num [NUM_CH];
    logic [DENSITY_BITS-1:0]  r_span_b;
    logic [NUM_BITS-1:0]      half_term;
    t_blend_item              n_item;
    t_blend_item              r_item;

    // stage A: (span - offset) * c0 and offset * c1
    always_comb begin
        cat_next = (i_item.cat >= STOP_COLD) ? STOP_COLD : i_item.cat + 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            n_prod0[c] = PROD_BITS'(i_item.span - i_item.offset)
                       * PROD_BITS'(stop_level(2'(c), i_item.cat));
            n_prod1[c] = PROD_BITS'(i_item.offset)
                       * PROD_BITS'(stop_level(2'(c), cat_next));
        end
    end

    // stage B: interpolated numerator, at most 99 * span
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_num[c] = r_prod0[c] + r_prod1[c];
        end
    end

    // stage C: FULL * num + span * 50 over span * 100 gives round-half-up
    always_comb begin
        half_term  = NUM_BITS'(r_span_b) * NUM_BITS'(HALF_PCT);
        n_item.den = DEN_BITS'(r_span_b) * DEN_BITS'(PCT_SCALE);
        for (int c = 0; c < NUM_CH; c++) begin
            n_item.numer[c] = (NUM_BITS'(r_num[c]) << CHANNEL_BITS)
                            - NUM_BITS'(r_num[c]) + half_term;
        end
    end

    assign stage_ready[3] = i_ready;
    for (genvar k = 0; k < 3; k++) begin : g_ready
        assign stage_ready[k] = !r_vld[k] || stage_ready[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_ready[0]) r_vld[0] <= i_valid;
            if (stage_ready[1]) r_vld[1] <= r_vld[0];
            if (stage_ready[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready[0]) begin
            r_prod0  <= n_prod0;
            r_prod1  <= n_prod1;
            r_span_a <= i_item.span;
        end
        if (stage_ready[1]) begin
            r_num    <= n_num;
            r_span_b <= r_span_a;
        end
        if (stage_ready[2]) begin
            r_item   <= n_item;
        end
    end

    assign o_ready = stage_ready[0];
    assign o_valid = r_vld[2];
    assign o_item  = r_item;

endmodule

@@ design/dhc_round_div.sv @@
// Round divider: restoring division of the three channel dividends by the common
// divisor, one quotient bit per register stage. Depends on dhc_pkg.
`timescale 1ns / 1ps

module dhc_round_div import dhc_pkg::*; (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  t_blend_item                         i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [NUM_CH-1:0][CHANNEL_BITS-1:0] o_level
);

    localparam int LAST = CHANNEL_BITS - 1;

    typedef struct packed {
        logic [NUM_CH-1:0][DEN_BITS-1:0]     part;
        logic [NUM_CH-1:0][CHANNEL_BITS-1:0] rest;
        logic [NUM_CH-1:0][CHANNEL_BITS-1:0] quot;
        logic [DEN_BITS-1:0]                 den;
    } t_div_stage;

    logic [LAST:0]   r_vld;
    logic [LAST+1:0] stage_ready;
    t_div_stage      r_st [LAST+1];
    t_div_stage      n_first;

    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage        o;
        logic [DEN_BITS:0] trial;
        logic              ge;
        o = s;
        for (int c = 0; c < NUM_CH; c++) begin
            trial = {s.part[c], s.rest[c][CHANNEL_BITS-1]};
            ge    = trial >= {1'b0, s.den};
            o.part[c] = ge ? DEN_BITS'(trial - {1'b0, s.den}) : trial[DEN_BITS-1:0];
            o.rest[c] = {s.rest[c][CHANNEL_BITS-2:0], 1'b0};
            o.quot[c] = {s.quot[c][CHANNEL_BITS-2:0], ge};
        end
        return o;
    endfunction

    // dividend < den << CHANNEL_BITS, so its upper part starts below den
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_first.part[c] = i_item.numer[c][NUM_BITS-1:CHANNEL_BITS];
            n_first.rest[c] = i_item.numer[c][CHANNEL_BITS-1:0];
            n_first.quot[c] = '0;
        end
        n_first.den = i_item.den;
    end

    assign stage_ready[LAST+1] = i_ready;
    for (genvar k = 0; k <= LAST; k++) begin : g_ready
        assign stage_ready[k] = !r_vld[k] || stage_ready[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_ready[0]) r_vld[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                if (stage_ready[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready[0]) r_st[0] <= div_step(n_first);
        for (int k = 1; k <= LAST; k++) begin
            if (stage_ready[k]) r_st[k] <= div_step(r_st[k-1]);
        end
    end

    assign o_ready = stage_ready[0];
    assign o_valid = r_vld[LAST];
    assign o_level = r_st[LAST].quot;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_st[0].den != '0)
        else $error("divisor is zero");

    for (genvar k = 0; k <= LAST; k++) begin : g_chk
        a_part_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[k] |-> (r_st[k].part[0] < r_st[k].den) && (r_st[k].part[1] < r_st[k].den)
                         && (r_st[k].part[2] < r_st[k].den))
            else $error("partial remainder not below divisor");
    end

    a_first_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !stage_ready[1] |=> r_vld[0] && $stable(r_st[0]))
        else $error("stalled divider stage changed");

endmodule

@@ sim/tb_diverging_heatmap_colormap_unit.sv @@
// Self-checking testbench for diverging_heatmap_colormap_unit: a color predictor
// in a small scoreboard class, plus tasks that drive samples and bounds.
// Depends on dhc_pkg and the design files under design/.
`timescale 1ns / 1ps

import dhc_pkg::*;

typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
} t_color;

typedef struct {
    logic [DENSITY_BITS-1:0] density;
    t_color                  color;
} t_color_due;

// Holds the bound registers as the block sees them and the colors still owed.
class color_scoreboard;
    int unsigned pal_red   [STOP_COUNT] = '{33, 55, 75, 87, 96, 99, 78, 50, 21, 0, 0};
    int unsigned pal_green [STOP_COUNT] = '{19, 32, 51, 76, 91, 96, 92, 80, 59, 40, 24};
    int unsigned pal_blue  [STOP_COUNT] = '{2, 4, 18, 49, 76, 89, 90, 76, 56, 37, 19};

    logic [DENSITY_BITS-1:0] floor_r;
    logic [DENSITY_BITS-1:0] center_r;
    logic [DENSITY_BITS-1:0] ceiling_r;
    t_color_due              colors_due [$];
    int                      errors;

    function new();
        floor_r   = FLOOR_RST;
        center_r  = CENTER_RST;
        ceiling_r = CEILING_RST;
        errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DENSITY_BITS-1:0] data);
        case (idx)
            CFG_FLOOR:   floor_r   = data;
            CFG_CENTER:  center_r  = data;
            CFG_CEILING: ceiling_r = data;
            default: ;
        endcase
    endfunction

    // round-half-up of FULL * ((span-t)*c0 + t*c1) / (100*span)
    function logic [CHANNEL_BITS-1:0] blend_level(input int unsigned c0, input int unsigned c1,
                                                  input longint unsigned t,
                                                  input longint unsigned span);
        longint unsigned num, den, prod, q;
        num  = (span - t) * c0 + t * c1;
        den  = PCT_SCALE * span;
        prod = num * ((64'd1 << CHANNEL_BITS) - 1);
        q    = prod / den;
        if (2 * (prod % den) >= den) q++;
        return q[CHANNEL_BITS-1:0];
    endfunction

    function t_color map_density(logic [DENSITY_BITS-1:0] d);
        longint unsigned x, lo, mid, hi, span, v, t;
        int unsigned band, nxt;
        t_color c;
        x = d; lo = floor_r; mid = center_r; hi = ceiling_r;
        span = 1;
        t = 0;
        if (x > hi) begin
            band = STOP_HOT;
        end else if (x > mid) begin
            span = hi - mid;
            v    = BAND_COUNT * (hi - x);
            band = int'(v / span);
            t    = v - band * span;
        end else if (x > lo) begin
            span = mid - lo;
            v    = BAND_COUNT * (mid - x);
            band = int'(v / span);
            t    = v - band * span;
            band = band + LOWER_BASE;
        end else begin
            band = STOP_COLD;
        end
        nxt = (band == STOP_COLD || t == 0) ? band : band + 1;
        c.red   = blend_level(pal_red[band],   pal_red[nxt],   t, span);
        c.green = blend_level(pal_green[band], pal_green[nxt], t, span);
        c.blue  = blend_level(pal_blue[band],  pal_blue[nxt],  t, span);
        return c;
    endfunction

    function void note_sample(logic [DENSITY_BITS-1:0] d);
        t_color_due due;
        due.density = d;
        due.color   = map_density(d);
        colors_due  = {colors_due, due};
    endfunction

    function void compare_level(string name, logic [DENSITY_BITS-1:0] d,
                                logic [CHANNEL_BITS-1:0] want, logic [CHANNEL_BITS-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch for density %h: expected %h, actual %h",
                     $time, name, d, want, got);
        end
    endfunction

    function void check_color(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                              logic [CHANNEL_BITS-1:0] b);
        t_color_due due;
        if (colors_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected color: expected none, actual %h %h %h",
                     $time, r, g, b);
            return;
        end
        due = colors_due.pop_front();
        compare_level("red",   due.density, due.color.red,   r);
        compare_level("green", due.density, due.color.green, g);
        compare_level("blue",  due.density, due.color.blue,  b);
    endfunction

    function int pending();
        return colors_due.size();
    endfunction
endclass

module tb_diverging_heatmap_colormap_unit;

    // Pipeline depth from the top-level header; used for the quiet time
    // between phases and at the end.
    localparam int PIPE_LATENCY = 15;
    // Watchdog limit, with a wide margin over the slowest correct run (about 520
    // transactions, 88% gaps or stalls).
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_ITEMS  = 55;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned DENSITY_MAX = 64'hFFFF_FFFF;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_cfg_wr_en      = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index      = '0;
    logic [DENSITY_BITS-1:0] i_cfg_data       = '0;
    logic                    i_in_valid       = 1'b0;
    logic [DENSITY_BITS-1:0] i_density_sample = '0;
    logic                    i_out_ready      = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [CHANNEL_BITS-1:0] o_red_level;
    logic [CHANNEL_BITS-1:0] o_green_level;
    logic [CHANNEL_BITS-1:0] o_blue_level;

    diverging_heatmap_colormap_unit uut (.*);

    color_scoreboard board;

    // Idle mix of the current phase, in percent of cycles.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;

    // Bounds being written for the current phase; also steer sample choice.
    logic [DENSITY_BITS-1:0] cur_floor   = FLOOR_RST;
    logic [DENSITY_BITS-1:0] cur_center  = CENTER_RST;
    logic [DENSITY_BITS-1:0] cur_ceiling = CEILING_RST;

    // Directed samples at reset bounds (floor 0, center 1.0, ceiling 2.0):
    // both extremes, exactly at each bound, one LSB above each bound and one LSB below the ceiling.
    logic [DENSITY_BITS-1:0] reset_bound_samples [10] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_7FFF, 32'h0001_0000, 32'h0001_0001,
        32'h0001_8000, 32'h0001_FFFF, 32'h0002_0000, 32'h0002_0001, 32'hFFFF_FFFF
    };
    // Directed samples at bounds 1000/2000/3000: band spans are 200 wide, so
    // exact band starts (zero offset) and mid-band points are both hit.
    logic [DENSITY_BITS-1:0] grid_samples [13] = '{
        32'd999, 32'd1000, 32'd1001, 32'd1200, 32'd1500, 32'd1999, 32'd2000,
        32'd2001, 32'd2200, 32'd2600, 32'd2999, 32'd3000, 32'd3001
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hang or a lost transaction ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output side: check every transaction taken at this edge, then pick the
    // ready level for the next cycle from the phase's stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_color(o_red_level, o_green_level, o_blue_level);
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Called at a rising edge. Optionally idles, then holds valid until the
    // transaction is taken; returns at the accepting edge with valid still high,
    // so back-to-back samples never drop valid.
    task automatic push_sample(input logic [DENSITY_BITS-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_density_sample <= value;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(value);
    endtask

    // Sender holds off until every owed color has come back. Always waits on
    // the clock before returning, so valid is never driven twice in one step.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Fully idle: drained, and the pipeline given its depth to empty out.
    task automatic settle();
        drain_results();
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
    endtask

    // Writes all three bounds, then junk to the unused index, which the
    // block must ignore.
    task automatic apply_bounds();
        logic [DENSITY_BITS-1:0] junk;
        junk = $urandom();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FLOOR;
        i_cfg_data  <= cur_floor;
        @(posedge i_clk);
        board.write_reg(CFG_FLOOR, cur_floor);
        i_cfg_index <= CFG_CENTER;
        i_cfg_data  <= cur_center;
        @(posedge i_clk);
        board.write_reg(CFG_CENTER, cur_center);
        i_cfg_index <= CFG_CEILING;
        i_cfg_data  <= cur_ceiling;
        @(posedge i_clk);
        board.write_reg(CFG_CEILING, cur_ceiling);
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= junk;
        @(posedge i_clk);
        board.write_reg(CFG_UNUSED, junk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random ordered bounds; the gaps have random widths so both wide and
    // very narrow bands show up.
    task automatic random_ordered_bounds();
        longint unsigned lo, mid, hi;
        lo  = $urandom() >> $urandom_range(31);
        mid = lo + ($urandom() >> $urandom_range(31));
        if (mid > DENSITY_MAX) mid = DENSITY_MAX;
        hi  = mid + ($urandom() >> $urandom_range(31));
        if (hi > DENSITY_MAX) hi = DENSITY_MAX;
        cur_floor   = lo[DENSITY_BITS-1:0];
        cur_center  = mid[DENSITY_BITS-1:0];
        cur_ceiling = hi[DENSITY_BITS-1:0];
    endtask

    task automatic choose_bounds(input int phase);
        case (phase)
            1: begin   // full range, widest bands
                cur_floor = 32'h0; cur_center = 32'h8000_0000; cur_ceiling = 32'hFFFF_FFFF;
            end
            2: begin   // lower span 5, upper span 1
                cur_floor = 32'd7; cur_center = 32'd12; cur_ceiling = 32'd13;
            end
            3: begin   // all bounds zero: only the two end stops
                cur_floor = 32'h0; cur_center = 32'h0; cur_ceiling = 32'h0;
            end
            4: begin   // inverted: floor above center above ceiling
                cur_floor = 32'hFFFF_FFFF; cur_center = 32'h10; cur_ceiling = 32'h8;
            end
            5: begin   // all bounds at the top
                cur_floor = 32'hFFFF_FFFF; cur_center = 32'hFFFF_FFFF;
                cur_ceiling = 32'hFFFF_FFFF;
            end
            7: begin   // unordered random bounds
                cur_floor = $urandom(); cur_center = $urandom(); cur_ceiling = $urandom();
            end
            8: begin   // center equals ceiling: upper half empty
                cur_floor = 32'h100; cur_center = 32'h20_0000; cur_ceiling = 32'h20_0000;
            end
            default: random_ordered_bounds();
        endcase
    endtask

    // Mix of full-range noise, samples near the bounds, samples inside the
    // bounds and samples on band starts.
    function automatic logic [DENSITY_BITS-1:0] pick_density();
        longint unsigned a, b, top, bottom, spot;
        logic [DENSITY_BITS-1:0] near;
        int unsigned k;
        a = (cur_floor < cur_ceiling) ? cur_floor : cur_ceiling;
        b = (cur_floor < cur_ceiling) ? cur_ceiling : cur_floor;
        case ($urandom_range(4))
            0: return $urandom();
            1: begin
                case ($urandom_range(2))
                    0:       near = cur_floor;
                    1:       near = cur_center;
                    default: near = cur_ceiling;
                endcase
                return near + DENSITY_BITS'($urandom_range(6)) - DENSITY_BITS'(3);
            end
            4: begin
                if ($urandom_range(1) == 1) begin
                    top = cur_ceiling; bottom = cur_center;
                end else begin
                    top = cur_center; bottom = cur_floor;
                end
                if (top <= bottom) return top[DENSITY_BITS-1:0];
                k    = $urandom_range(BAND_COUNT);
                spot = top - ((top - bottom) * k) / BAND_COUNT + $urandom_range(2) - 1;
                return spot[DENSITY_BITS-1:0];
            end
            default: begin
                spot = a + ({$urandom(), $urandom()} % (b - a + 1));
                return spot[DENSITY_BITS-1:0];
            end
        endcase
    endfunction

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling: reset bounds first, then an exact grid.
        foreach (reset_bound_samples[i]) push_sample(reset_bound_samples[i]);
        settle();
        cur_floor = 32'd1000; cur_center = 32'd2000; cur_ceiling = 32'd3000;
        apply_bounds();
        foreach (grid_samples[i]) push_sample(grid_samples[i]);
        settle();

        // Random phases: each gets new bounds and cycles through the idle
        // mixes none / sender 88% / receiver 88% / both 20%.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            choose_bounds(phase);
            apply_bounds();
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
                default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_sample(pick_density());
                // Sender holds off mid-stream until all colors are back.
                if ((phase == 0 && n == PHASE_ITEMS / 2) || $urandom_range(199) == 0)
                    drain_results();
            end
            settle();
        end

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
